// ----- src/i2cmbe_pkg.sv -----
`default_nettype none

package i2cmbe_pkg;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_SEND      = 3'd2,
        OP_READ      = 3'd3,
        OP_WAIT_ACK  = 3'd4,
        OP_ACK       = 3'd5,
        OP_NACK      = 3'd6,
        OP_BUS_RESET = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        PIN_LOW  = 2'd0,
        PIN_HIGH = 2'd1,
        PIN_KEEP = 2'd2
    } pin_t;

    typedef struct packed {
        pin_t scl;
        pin_t sda;
        logic sample;
    } seg_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } out_t;

    // classified request as held in the queue
    typedef struct packed {
        logic       cmd_valid;
        op_t        cmd;
        logic [4:0] seg_total;
        logic [7:0] load_byte;
        logic       sda_in;
    } entry_t;

    localparam logic [15:0] PHASE_RESET = 16'd100;
    localparam logic [15:0] PHASE_MAX   = 16'hFFFF;

    function automatic seg_t mk_seg(pin_t scl, pin_t sda, logic smp);
        seg_t s;
        s.scl    = scl;
        s.sda    = sda;
        s.sample = smp;
        return s;
    endfunction

    function automatic logic [4:0] seg_total(op_t cmd);
        logic [4:0] t;
        case (cmd)
            OP_START:     t = 5'd3;
            OP_STOP:      t = 5'd1;
            OP_SEND:      t = 5'd24;
            OP_READ:      t = 5'd16;
            OP_BUS_RESET: t = 5'd25;
            default:      t = 5'd3;
        endcase
        return t;
    endfunction

    function automatic seg_t start_seg(logic [1:0] k);
        seg_t s;
        case (k)
            2'd0:    s = mk_seg(PIN_HIGH, PIN_HIGH, 1'b0);
            2'd1:    s = mk_seg(PIN_KEEP, PIN_LOW, 1'b0);
            default: s = mk_seg(PIN_LOW, PIN_KEEP, 1'b0);
        endcase
        return s;
    endfunction

    function automatic seg_t seg_of(op_t cmd, logic [4:0] k, logic [7:0] sr);
        seg_t       s;
        logic [8:0] prod;
        logic [3:0] b;
        logic [4:0] r;
        logic [4:0] j;
        prod = 9'(k) * 9'd11;   // k / 3 for k < 32
        b    = prod[8:5];
        r    = k - 5'(6'(b) * 6'd3);
        j    = k - 5'd3;
        case (cmd)
            OP_START:
                s = start_seg(k[1:0] > 2'd2 ? 2'd2 : k[1:0]);
            OP_STOP:
                s = mk_seg(PIN_HIGH, PIN_LOW, 1'b0);
            OP_SEND:
                if (r == 5'd0)
                    s = mk_seg(PIN_KEEP, sr[3'd7 - b[2:0]] ? PIN_HIGH : PIN_LOW, 1'b0);
                else if (r == 5'd1)
                    s = mk_seg(PIN_HIGH, PIN_KEEP, 1'b0);
                else
                    s = mk_seg(PIN_LOW, (b == 4'd7) ? PIN_HIGH : PIN_KEEP, 1'b0);
            OP_READ:
                if (!k[0])
                    s = mk_seg(PIN_HIGH, PIN_KEEP, 1'b1);
                else
                    s = mk_seg(PIN_LOW, PIN_KEEP, 1'b0);
            OP_WAIT_ACK, OP_ACK, OP_NACK:
                if (k == 5'd0)
                    s = mk_seg(PIN_KEEP, (cmd == OP_ACK) ? PIN_LOW : PIN_HIGH, 1'b0);
                else if (k == 5'd1)
                    s = mk_seg(PIN_HIGH, PIN_KEEP, cmd == OP_WAIT_ACK);
                else
                    s = mk_seg(PIN_LOW, PIN_KEEP, 1'b0);
            default:
                if (k < 5'd3)
                    s = start_seg(k[1:0]);
                else if (k < 5'd21)
                    if (!j[0])
                        s = mk_seg(PIN_HIGH, (j == 5'd0) ? PIN_HIGH : PIN_KEEP, 1'b0);
                    else
                        s = mk_seg(PIN_LOW, PIN_KEEP, 1'b0);
                else if (k < 5'd24)
                    s = start_seg(2'(k - 5'd21));
                else
                    s = mk_seg(PIN_HIGH, PIN_LOW, 1'b0);
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- src/i2cmbe_front.sv -----
`default_nettype none

module i2cmbe_front (
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire i2cmbe_pkg::in_t   in_data,
    input  wire logic              q_full,
    output logic                   q_push,
    output i2cmbe_pkg::entry_t     q_entry
);

    i2cmbe_pkg::op_t op;

    always_comb
    begin
        op                = i2cmbe_pkg::op_t'(in_data.opcode);
        in_stall          = q_full;
        q_push            = in_valid && !q_full;
        q_entry.cmd_valid = in_data.cmd_valid;
        q_entry.cmd       = op;
        q_entry.seg_total = i2cmbe_pkg::seg_total(op);
        q_entry.load_byte = (op == i2cmbe_pkg::OP_SEND) ? in_data.tx_byte : 8'd0;
        q_entry.sda_in    = in_data.sda_in;
    end

endmodule

`default_nettype wire

// ----- src/i2cmbe_queue.sv -----
`default_nettype none

module i2cmbe_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire i2cmbe_pkg::entry_t  push_entry,
    output logic                     full,
    input  wire logic                pop,
    output i2cmbe_pkg::entry_t       pop_entry,
    output logic                     empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2cmbe_pkg::entry_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    always_comb
    begin
        full      = (count_reg == CW'(DEPTH));
        empty     = (count_reg == '0);
        do_push   = push && !full;
        do_pop    = pop && !empty;
        pop_entry = mem[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = rd_ptr_reg;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/i2cmbe_seq.sv -----
`default_nettype none

module i2cmbe_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [15:0]         phase_ticks,
    input  wire logic                q_empty,
    input  wire i2cmbe_pkg::entry_t  q_entry,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output i2cmbe_pkg::out_t         out_data
);

    i2cmbe_pkg::op_t  cmd_reg, cmd_next;
    logic [4:0]       total_reg, total_next;
    logic [4:0]       step_reg, step_next;
    logic [15:0]      pc_reg, pc_next;
    logic [7:0]       shift_reg, shift_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic [7:0]       rx_reg, rx_next;
    logic             ack_reg, ack_next;
    logic             out_valid_reg, out_valid_next;
    i2cmbe_pkg::out_t out_reg, out_next;

    logic [15:0]      pt;
    logic [4:0]       idx;
    logic             done;
    i2cmbe_pkg::seg_t seg;

    always_comb
    begin
        pt    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
        q_pop = !q_empty && (!out_valid_reg || !out_stall);

        cmd_next   = cmd_reg;
        total_next = total_reg;
        step_next  = step_reg;
        pc_next    = pc_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rx_next    = rx_reg;
        ack_next   = ack_reg;
        done       = 1'b0;

        if (step_reg == 5'd0 && q_entry.cmd_valid)
        begin
            cmd_next   = q_entry.cmd;
            total_next = q_entry.seg_total;
            step_next  = 5'd1;
            pc_next    = 16'd0;
            shift_next = q_entry.load_byte;
        end

        idx = step_next - 5'd1;
        seg = i2cmbe_pkg::seg_of(cmd_next, idx, shift_next);

        if (step_next != 5'd0)
        begin
            if (pc_next == 16'd0)
            begin
                if (idx < total_next)
                begin
                    if (seg.scl != i2cmbe_pkg::PIN_KEEP)
                        scl_next = (seg.scl == i2cmbe_pkg::PIN_HIGH);
                    if (seg.sda != i2cmbe_pkg::PIN_KEEP)
                        sda_next = (seg.sda == i2cmbe_pkg::PIN_HIGH);
                    pc_next = 16'd1;
                end
                else
                begin
                    if (cmd_next inside {i2cmbe_pkg::OP_STOP, i2cmbe_pkg::OP_ACK,
                                         i2cmbe_pkg::OP_BUS_RESET})
                        sda_next = 1'b1;
                    if (cmd_next == i2cmbe_pkg::OP_READ)
                        rx_next = shift_next;
                    step_next = 5'd0;
                    done      = 1'b1;
                end
            end
            else if (pc_next < i2cmbe_pkg::PHASE_MAX)
            begin
                pc_next = pc_next + 16'd1;
            end

            if (step_next != 5'd0 && pc_next >= pt)
            begin
                if (seg.sample)
                begin
                    if (cmd_next == i2cmbe_pkg::OP_READ)
                        shift_next = {shift_next[6:0], q_entry.sda_in};
                    else
                        ack_next = q_entry.sda_in;
                end
                step_next = step_next + 5'd1;
                pc_next   = 16'd0;
            end
        end

        out_next.scl_out     = scl_next;
        out_next.sda_out     = sda_next;
        out_next.busy_res    = (step_next != 5'd0);
        out_next.done_res    = done;
        out_next.rx_byte     = rx_next;
        out_next.ack_missing = ack_next;

        if (q_pop)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        out_valid = out_valid_reg;
        out_data  = out_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= i2cmbe_pkg::OP_START;
            total_reg     <= 5'd0;
            step_reg      <= 5'd0;
            pc_reg        <= 16'd0;
            shift_reg     <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            rx_reg        <= 8'd0;
            ack_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                cmd_reg   <= cmd_next;
                total_reg <= total_next;
                step_reg  <= step_next;
                pc_reg    <= pc_next;
                shift_reg <= shift_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                rx_reg    <= rx_next;
                ack_reg   <= ack_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/i2c_master_bit_engine_top.sv -----
// I2C master bit engine, open-drain SCL/SDA drive.
// Input channel (in_valid/in_stall/in_data): one request per bus tick, carrying
// an optional command, the byte to send and the sampled SDA level.
// Output channel (out_valid/out_stall/out_data): exactly one result per request,
// in order: pin drive levels, busy, done, last read byte, last ack sample.
// Front stage classifies each request into a queue of QUEUE_DEPTH entries; the
// sequencer pops one entry per cycle into a registered result, unless stalled.
// Each result is registered from its queue entry when the sequencer pops it.
// Throughput: 1 request per cycle while the receiver does not stall.
// When the receiver stalls, the result holds, the queue fills and in_stall rises
// once it is full; nothing is dropped.
// cfg_we/cfg_wdata write phase_ticks (ticks per delay phase, 0 acts as 1);
// write only while idle.
// Reset: queue empty, SCL/SDA released, sequencer idle, phase_ticks = 100.
`default_nettype none

module i2c_master_bit_engine_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire i2cmbe_pkg::in_t   in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output i2cmbe_pkg::out_t       out_data,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_wdata
);

    logic [15:0]        phase_reg;
    logic               q_full, q_push, q_pop, q_empty;
    i2cmbe_pkg::entry_t push_entry, pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= i2cmbe_pkg::PHASE_RESET;
        else if (cfg_we)
            phase_reg <= cfg_wdata;
    end

    i2cmbe_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    i2cmbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    i2cmbe_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .phase_ticks (phase_reg),
        .q_empty     (q_empty),
        .q_entry     (pop_entry),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire
